[design/tms_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Turing machine step core package
// Shared field widths, codes, rule entry layout and the search response.
// ----------------------------------------------------------------------------
package tms_pkg;

  localparam int ActW     = 3;
  localparam int SlotW    = 6;
  localparam int StateW   = 4;
  localparam int SymW     = 8;
  localparam int MoveW    = 2;
  localparam int PosW     = 8;
  localparam int StatW    = 3;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 8;

  localparam int RuleSlotsDef  = 64;
  localparam int TapeCellsDef  = 256;
  localparam int StateCountDef = 16;

  localparam logic [SymW-1:0]   BlankSym        = 8'h20;
  localparam logic [StateW-1:0] ResetStartState = 4'd0;
  localparam logic [StateW-1:0] ResetHaltState  = 4'd14;
  localparam logic [PosW-1:0]   ResetStartHead  = 8'd1;

  typedef enum logic [ActW-1:0] {
    ACT_LOAD    = 3'd0,
    ACT_WRITE   = 3'd1,
    ACT_STEP    = 3'd2,
    ACT_READ    = 3'd3,
    ACT_RESTART = 3'd4
  } action_e;

  typedef enum logic [StatW-1:0] {
    ST_OK       = 3'd0,
    ST_HALTED   = 3'd1,
    ST_NO_RULE  = 3'd2,
    ST_BAD_MOVE = 3'd3,
    ST_OFF_TAPE = 3'd4
  } status_e;

  typedef enum logic [MoveW-1:0] {
    MOVE_STAY  = 2'd0,
    MOVE_RIGHT = 2'd1,
    MOVE_LEFT  = 2'd2,
    MOVE_BAD   = 2'd3
  } move_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_START_STATE = 2'd0,
    CFG_HALT_STATE  = 2'd1,
    CFG_START_HEAD  = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_SEARCH,
    S_FETCH,
    S_FWAIT
  } tms_state_e;

  typedef struct packed {
    logic              valid;
    logic [StateW-1:0] st;
    logic [SymW-1:0]   rd;
    logic [SymW-1:0]   wr;
    move_e             mv;
    logic [StateW-1:0] nx;
  } rule_t;

  typedef struct packed {
    logic  done;
    logic  hit;
    rule_t rule;
  } srch_rsp_t;

  // Only the cells that an 8-bit position can reach are ever stored.
  function automatic int tape_span(int cells);
    return (cells < (1 << PosW)) ? cells : (1 << PosW);
  endfunction

endpackage

[design/tms_tape_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tape store
// Single write port and a registered read port over the reachable cells.
// ----------------------------------------------------------------------------
module tms_tape_unit #(
  parameter int TAPE_CELLS = tms_pkg::TapeCellsDef
) (
  input  logic                                           clk_i,
  input  logic                                           wr_en_i,
  input  logic [$clog2(tms_pkg::tape_span(TAPE_CELLS))-1:0] wr_addr_i,
  input  logic [tms_pkg::SymW-1:0]                       wr_data_i,
  input  logic                                           rd_en_i,
  input  logic [$clog2(tms_pkg::tape_span(TAPE_CELLS))-1:0] rd_addr_i,
  output logic [tms_pkg::SymW-1:0]                       rd_data_o
);
  import tms_pkg::*;

  localparam int TapeSpan = tape_span(TAPE_CELLS);

  logic [SymW-1:0] mem_q [TapeSpan];
  logic [SymW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[design/tms_rule_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rule table and search engine
// Holds the rule table and scans it one slot per cycle in slot order,
// stopping at the first valid entry that matches state and symbol.
// ----------------------------------------------------------------------------
module tms_rule_unit #(
  parameter int RULE_SLOTS = tms_pkg::RuleSlotsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              wr_en_i,
  input  logic [$clog2(RULE_SLOTS)-1:0]     wr_addr_i,
  input  tms_pkg::rule_t                    wr_data_i,
  input  logic                              start_i,
  input  logic [tms_pkg::StateW-1:0]        cur_state_i,
  input  logic [tms_pkg::SymW-1:0]          sym_i,
  output tms_pkg::srch_rsp_t                rsp_o
);
  import tms_pkg::*;

  localparam int RiW = $clog2(RULE_SLOTS);

  rule_t          mem_q [RULE_SLOTS];
  rule_t          rd_data_q;
  logic [RiW-1:0] iss_q, iss_d;
  logic           issue_q, issue_d;
  logic           cmpv_q, cmpv_d;
  logic           last_q, last_d;
  logic           iss_last;
  logic           match;
  logic           done;
  logic           rd_en;

  assign iss_last = (iss_q == RiW'(RULE_SLOTS - 1));
  assign match    = cmpv_q && rd_data_q.valid && (rd_data_q.st == cur_state_i) &&
                    (rd_data_q.rd == sym_i);
  assign done     = cmpv_q && (match || last_q);
  assign rd_en    = issue_q && !done;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[iss_q];
    end
  end

  always_comb begin
    iss_d   = iss_q;
    issue_d = issue_q;
    cmpv_d  = 1'b0;
    last_d  = 1'b0;
    if (start_i) begin
      iss_d   = '0;
      issue_d = 1'b1;
    end else if (done) begin
      issue_d = 1'b0;
    end else if (issue_q) begin
      cmpv_d = 1'b1;
      last_d = iss_last;
      if (iss_last) begin
        issue_d = 1'b0;
      end else begin
        iss_d = iss_q + RiW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iss_q   <= '0;
      issue_q <= 1'b0;
      cmpv_q  <= 1'b0;
      last_q  <= 1'b0;
    end else begin
      iss_q   <= iss_d;
      issue_q <= issue_d;
      cmpv_q  <= cmpv_d;
      last_q  <= last_d;
    end
  end

  assign rsp_o.done = done;
  assign rsp_o.hit  = match;
  assign rsp_o.rule = rd_data_q;

endmodule

[design/turing_machine_step_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Turing machine step core
// Single-tape Turing machine with a loadable rule table and a tape store.
// ----------------------------------------------------------------------------
// Items arrive on the input channel (in_valid_i / in_ready_o) and each gives
// exactly one result beat on the output channel (out_valid_o / out_ready_i).
// Configuration writes use their own channel and are always taken.
// One item is worked on at a time. A load, tape write, tape read or restart
// passes through the execute, fetch and fetch-wait states to its result, and
// the block is ready for the next item in the same cycle as that result. A step
// scans the rule table one slot per cycle through the single read port of the
// rule memory, then on a hit fetches the symbol under the new head position.
// A step that finds no rule or fails its move skips that fetch.
// A finished result waits in the output register while the next item is
// taken; the following result is held back until the receiver takes the
// waiting beat, and no result is lost when the receiver stalls.
// After reset the block sweeps both memories, invalidating every rule and
// filling every stored tape cell with blanks; no item is taken during that
// sweep.
// ----------------------------------------------------------------------------
module turing_machine_step_core #(
  parameter int RULE_SLOTS  = tms_pkg::RuleSlotsDef,
  parameter int TAPE_CELLS  = tms_pkg::TapeCellsDef,
  parameter int STATE_COUNT = tms_pkg::StateCountDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [tms_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [tms_pkg::CfgDataW-1:0]    cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [tms_pkg::ActW-1:0]        action_i,
  input  logic [tms_pkg::SlotW-1:0]       rule_slot_i,
  input  logic [tms_pkg::StateW-1:0]      rule_state_i,
  input  logic [tms_pkg::SymW-1:0]        rule_read_i,
  input  logic [tms_pkg::SymW-1:0]        rule_write_i,
  input  logic [tms_pkg::MoveW-1:0]       rule_move_i,
  input  logic [tms_pkg::StateW-1:0]      rule_next_i,
  input  logic                            rule_enable_i,
  input  logic [tms_pkg::PosW-1:0]        cell_position_i,
  input  logic [tms_pkg::SymW-1:0]        cell_symbol_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [tms_pkg::StatW-1:0]       status_o,
  output logic [tms_pkg::StateW-1:0]      machine_state_o,
  output logic [tms_pkg::PosW-1:0]        head_position_o,
  output logic [tms_pkg::SymW-1:0]        read_symbol_o
);
  import tms_pkg::*;

  localparam int TapeSpan = tape_span(TAPE_CELLS);
  localparam int TaW      = $clog2(TapeSpan);
  localparam int RiW      = $clog2(RULE_SLOTS);
  localparam int ClearLen = (RULE_SLOTS > TapeSpan) ? RULE_SLOTS : TapeSpan;
  localparam int ClrW     = $clog2(ClearLen);
  localparam int PosCmpW  = PosW + 1;
  localparam int SlotCmpW = ((RiW > SlotW) ? RiW : SlotW) + 1;
  localparam int StCmpW   = (($clog2(STATE_COUNT + 1) > StateW) ?
                             $clog2(STATE_COUNT + 1) : StateW) + 1;

  tms_state_e        state_q, state_d;
  logic [ClrW-1:0]   clr_q, clr_d;
  logic [StateW-1:0] cur_q, cur_d;
  logic [PosW-1:0]   head_q, head_d;
  logic [PosW-1:0]   addr_q, addr_d;
  status_e           status_q, status_d;
  logic [StateW-1:0] start_state_q, halt_state_q;
  logic [PosW-1:0]   start_head_q;

  logic [ActW-1:0]   act_q;
  logic [SlotW-1:0]  slot_q;
  logic [StateW-1:0] rst_q;
  logic [SymW-1:0]   rrd_q, rwr_q;
  logic [MoveW-1:0]  rmv_q;
  logic [StateW-1:0] rnx_q;
  logic              ren_q;
  logic [PosW-1:0]   cell_q;
  logic [SymW-1:0]   csym_q;

  logic              out_valid_q, out_valid_d;
  logic              out_load;
  status_e           out_status_q;
  logic [StateW-1:0] out_state_q;
  logic [PosW-1:0]   out_head_q;
  logic [SymW-1:0]   out_sym_q, out_sym_d;

  logic              tw_en, tr_en, rw_en, srch_start;
  logic [PosW-1:0]   tw_pos, tr_pos;
  logic [SymW-1:0]   tw_data;
  logic [TaW-1:0]    tw_addr;
  logic [SymW-1:0]   tape_rdata;
  logic [RiW-1:0]    rw_addr;
  rule_t             rw_data;
  srch_rsp_t         srch_rsp;
  logic              clr_rule, clr_tape, clr_last;
  logic              head_in, head_r_in, cell_in, addr_in, tw_in_span, load_ok;
  logic [PosW-1:0]   head_r, head_l;

  assign clr_rule   = {1'b0, clr_q} < (ClrW + 1)'(RULE_SLOTS);
  assign clr_tape   = {1'b0, clr_q} < (ClrW + 1)'(TapeSpan);
  assign clr_last   = (clr_q == ClrW'(ClearLen - 1));
  assign head_in    = {1'b0, head_q} < PosCmpW'(TapeSpan);
  assign head_r_in  = ({1'b0, head_q} + PosCmpW'(1)) < PosCmpW'(TapeSpan);
  assign cell_in    = {1'b0, cell_q} < PosCmpW'(TapeSpan);
  assign addr_in    = {1'b0, addr_q} < PosCmpW'(TapeSpan);
  assign tw_in_span = {1'b0, tw_pos} < PosCmpW'(TapeSpan);
  assign head_r     = head_q + PosW'(1);
  assign head_l     = head_q - PosW'(1);
  assign load_ok    = (SlotCmpW'(slot_q) < SlotCmpW'(RULE_SLOTS)) &&
                      (StCmpW'(rst_q) < StCmpW'(STATE_COUNT)) &&
                      (StCmpW'(rnx_q) < StCmpW'(STATE_COUNT));
  assign tw_addr    = (state_q == S_CLEAR) ? clr_q[TaW-1:0] : TaW'(tw_pos);

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    cur_d       = cur_q;
    head_d      = head_q;
    addr_d      = addr_q;
    status_d    = status_q;
    in_ready_o  = 1'b0;
    tw_en       = 1'b0;
    tw_pos      = head_q;
    tw_data     = BlankSym;
    tr_en       = 1'b0;
    tr_pos      = addr_q;
    rw_en       = 1'b0;
    rw_addr     = RiW'(slot_q);
    rw_data     = '{valid: ren_q, st: rst_q, rd: rrd_q, wr: rwr_q,
                    mv: move_e'(rmv_q), nx: rnx_q};
    srch_start  = 1'b0;
    out_load    = 1'b0;
    out_sym_d   = addr_in ? tape_rdata : '0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      S_CLEAR: begin
        rw_en   = clr_rule;
        rw_addr = clr_q[RiW-1:0];
        rw_data = '0;
        tw_en   = clr_tape;
        clr_d   = clr_q + ClrW'(1);
        if (clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        addr_d   = head_q;
        status_d = ST_OK;
        state_d  = S_FETCH;
        case (action_e'(act_q))
          ACT_LOAD: begin
            rw_en = load_ok;
          end
          ACT_WRITE: begin
            addr_d  = cell_q;
            tw_pos  = cell_q;
            tw_data = csym_q;
            tw_en   = cell_in;
            if (!cell_in) begin
              status_d = ST_OFF_TAPE;
            end
          end
          ACT_READ: begin
            addr_d = cell_q;
            if (!cell_in) begin
              status_d = ST_OFF_TAPE;
            end
          end
          ACT_RESTART: begin
            cur_d  = start_state_q;
            head_d = start_head_q;
            addr_d = start_head_q;
          end
          ACT_STEP: begin
            if (cur_q == halt_state_q) begin
              status_d = ST_HALTED;
            end else if (!head_in) begin
              status_d = ST_OFF_TAPE;
            end else begin
              tr_en      = 1'b1;
              tr_pos     = head_q;
              srch_start = 1'b1;
              state_d    = S_SEARCH;
            end
          end
          default: begin
          end
        endcase
      end
      S_SEARCH: begin
        tw_data = srch_rsp.rule.wr;
        if (srch_rsp.done) begin
          state_d = S_FWAIT;
          if (!srch_rsp.hit) begin
            status_d = ST_NO_RULE;
          end else begin
            case (srch_rsp.rule.mv)
              MOVE_RIGHT: begin
                if (!head_r_in) begin
                  status_d = ST_OFF_TAPE;
                end else begin
                  tw_en   = 1'b1;
                  head_d  = head_r;
                  addr_d  = head_r;
                  cur_d   = srch_rsp.rule.nx;
                  state_d = S_FETCH;
                end
              end
              MOVE_LEFT: begin
                if (head_q == '0) begin
                  status_d = ST_OFF_TAPE;
                end else begin
                  tw_en   = 1'b1;
                  head_d  = head_l;
                  addr_d  = head_l;
                  cur_d   = srch_rsp.rule.nx;
                  state_d = S_FETCH;
                end
              end
              MOVE_STAY: begin
                tw_en   = 1'b1;
                cur_d   = srch_rsp.rule.nx;
                state_d = S_FETCH;
              end
              default: begin
                status_d = ST_BAD_MOVE;
              end
            endcase
          end
        end
      end
      S_FETCH: begin
        tr_en   = 1'b1;
        state_d = S_FWAIT;
      end
      S_FWAIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      cur_q       <= ResetStartState;
      head_q      <= ResetStartHead;
      addr_q      <= '0;
      status_q    <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      cur_q       <= cur_d;
      head_q      <= head_d;
      addr_q      <= addr_d;
      status_q    <= status_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_state_q <= ResetStartState;
      halt_state_q  <= ResetHaltState;
      start_head_q  <= ResetStartHead;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_START_STATE: start_state_q <= cfg_data_i[StateW-1:0];
        CFG_HALT_STATE:  halt_state_q  <= cfg_data_i[StateW-1:0];
        CFG_START_HEAD:  start_head_q  <= cfg_data_i[PosW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      act_q  <= action_i;
      slot_q <= rule_slot_i;
      rst_q  <= rule_state_i;
      rrd_q  <= rule_read_i;
      rwr_q  <= rule_write_i;
      rmv_q  <= rule_move_i;
      rnx_q  <= rule_next_i;
      ren_q  <= rule_enable_i;
      cell_q <= cell_position_i;
      csym_q <= cell_symbol_i;
    end
    if (out_load) begin
      out_status_q <= status_q;
      out_state_q  <= cur_q;
      out_head_q   <= head_q;
      out_sym_q    <= out_sym_d;
    end
  end

  tms_rule_unit #(
    .RULE_SLOTS (RULE_SLOTS)
  ) u_rule (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_en_i     (rw_en),
    .wr_addr_i   (rw_addr),
    .wr_data_i   (rw_data),
    .start_i     (srch_start),
    .cur_state_i (cur_q),
    .sym_i       (tape_rdata),
    .rsp_o       (srch_rsp)
  );

  tms_tape_unit #(
    .TAPE_CELLS (TAPE_CELLS)
  ) u_tape (
    .clk_i     (clk_i),
    .wr_en_i   (tw_en),
    .wr_addr_i (tw_addr),
    .wr_data_i (tw_data),
    .rd_en_i   (tr_en),
    .rd_addr_i (TaW'(tr_pos)),
    .rd_data_o (tape_rdata)
  );

  assign cfg_ready_o     = 1'b1;
  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign machine_state_o = out_state_q;
  assign head_position_o = out_head_q;
  assign read_symbol_o   = out_sym_q;

  // The rule search only finishes while the sequencer waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    srch_rsp.done |-> (state_q == S_SEARCH))
    else $error("rule search finished outside the search phase");

  // A new result beat only follows the final read of an item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> ($past(state_q) == S_FWAIT))
    else $error("result beat raised without a completed item");

  // Outside the clearing sweep the tape is only written inside its span.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tw_en && (state_q != S_CLEAR)) |-> tw_in_span)
    else $error("tape write outside the stored cells");

  // The head moves only on a restart or a completed step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(head_q) |-> ($past(state_q) == S_EXEC || $past(state_q) == S_SEARCH))
    else $error("head position changed outside an item");

endmodule
